// ----- rtl/sha_pkg.sv -----
// sha_pkg: shared types, round constants and round functions for the sha-256 stream hasher
// no dependencies
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam int QDepth = 4;
  localparam int QPtrW  = 2;

  localparam logic [7:0]  PadByte  = 8'h80;
  localparam logic [5:0]  LenPos   = 6'd56;
  localparam logic [63:0] BitsPerByte = 64'd8;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sml_s0(input logic [31:0] x);
    sml_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_s1(input logic [31:0] x);
    sml_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ----- rtl/sha_front.sv -----
// sha_front: input item queue; drops items that carry neither a byte nor an end mark
// depends on sha_pkg
module sha_front import sha_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_item,
  output logic     q_valid,
  output in_item_t q_item,
  input  logic     q_take
);

  in_item_t           mem_r [QDepth];
  logic [QPtrW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QPtrW:0]     cnt_r, cnt_nxt;
  logic               store;

  assign in_full = (cnt_r == (QPtrW+1)'(QDepth));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_r];
  // idle items change nothing, so they never enter the queue
  assign store   = in_push && !in_full && (in_item.byte_present || in_item.end_of_message);

  always_comb begin
    wr_nxt  = store ? wr_r + 1'b1 : wr_r;
    rd_nxt  = q_take ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (QPtrW+1)'(store) - (QPtrW+1)'(q_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      mem_r[wr_r] <= in_item;
    end
  end

endmodule

// ----- rtl/sha_core.sv -----
// sha_core: block packing, padding sequencer, 64-round compression and digest readout
// depends on sha_pkg
module sha_core import sha_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  in_item_t  q_item,
  output logic      q_take,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD80 = 3'd1;
  localparam logic [2:0] S_PADZ  = 3'd2;
  localparam logic [2:0] S_LEN   = 3'd3;
  localparam logic [2:0] S_INIT  = 3'd4;
  localparam logic [2:0] S_ROUND = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]  state_r, state_nxt, ret_r, ret_nxt;
  logic [5:0]  pos_r, pos_nxt, rnd_r, rnd_nxt;
  logic [63:0] blen_r, blen_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [31:0] h_r [8];
  logic [31:0] h_nxt [8];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];

  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [31:0] w_new, t1, t2;

  assign q_take    = (state_r == S_IDLE) && q_valid;
  assign out_empty = (state_r != S_OUT);
  assign out_item  = '{digest_word: h_r[idx_r], word_index: idx_r,
                       last_word: (idx_r == 3'd7)};

  always_comb begin
    w_new = (rnd_r < 6'd16) ? w_r[0]
          : w_r[0] + sml_s0(w_r[1]) + w_r[9] + sml_s1(w_r[14]);
    t1 = v_r[7] + big_s1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
       + RoundK[rnd_r] + w_new;
    t2 = big_s0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    pos_nxt   = pos_r;
    rnd_nxt   = rnd_r;
    blen_nxt  = blen_r;
    idx_nxt   = idx_r;
    h_nxt     = h_r;
    v_nxt     = v_r;
    w_nxt     = w_r;
    wr_en     = 1'b0;
    wr_byte   = '0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.byte_present) begin
            wr_en    = 1'b1;
            wr_byte  = q_item.data_byte;
            blen_nxt = blen_r + BitsPerByte;
            pos_nxt  = pos_r + 6'd1;
            if (pos_r == 6'd63) begin
              state_nxt = S_INIT;
              ret_nxt   = q_item.end_of_message ? S_PAD80 : S_IDLE;
            end else if (q_item.end_of_message) begin
              state_nxt = S_PAD80;
            end
          end else begin
            state_nxt = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        wr_en   = 1'b1;
        wr_byte = PadByte;
        pos_nxt = pos_r + 6'd1;
        if (pos_r == 6'd63) begin
          state_nxt = S_INIT;
          ret_nxt   = S_PADZ;
        end else begin
          state_nxt = S_PADZ;
        end
      end
      S_PADZ: begin
        if (pos_r == LenPos) begin
          state_nxt = S_LEN;
        end else begin
          wr_en   = 1'b1;
          pos_nxt = pos_r + 6'd1;
          if (pos_r == 6'd63) begin
            state_nxt = S_INIT;
            ret_nxt   = S_PADZ;
          end
        end
      end
      S_LEN: begin
        w_nxt[14] = blen_r[63:32];
        w_nxt[15] = blen_r[31:0];
        state_nxt = S_INIT;
        ret_nxt   = S_OUT;
      end
      S_INIT: begin
        v_nxt     = h_r;
        rnd_nxt   = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = w_new;
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        for (int i = 0; i < 8; i++) begin
          h_nxt[i] = h_r[i] + v_r[i];
        end
        state_nxt = ret_r;
        idx_nxt   = '0;
      end
      S_OUT: begin
        if (out_pop) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            h_nxt     = InitH;
            pos_nxt   = '0;
            blen_nxt  = '0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // big-endian byte lanes within each schedule word
    if (wr_en) begin
      w_nxt[pos_r[5:2]][8*(3 - pos_r[1:0]) +: 8] = wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      pos_r   <= '0;
      rnd_r   <= '0;
      blen_r  <= '0;
      idx_r   <= '0;
      h_r     <= InitH;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      pos_r   <= pos_nxt;
      rnd_r   <= rnd_nxt;
      blen_r  <= blen_nxt;
      idx_r   <= idx_nxt;
      h_r     <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    w_r <= w_nxt;
  end

endmodule

// ----- rtl/sha256_stream_hash.sv -----
// sha256_stream_hash: top level of the sha-256 byte stream hasher
// bytes pack at one per cycle while the core is idle; a full block runs load, 64 rounds, fold
// message end: 0x80, zeros to byte 56, 64-bit length, one or two compressions, then 8 words
// stalls: no new byte is taken while a block compresses; the queue buffers up to 4 items
// reset: synchronous active-low rst_n empties the input queue and restores the initial hash
// depends on sha_pkg, sha_front, sha_core
module sha256_stream_hash import sha_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  // queue handoff between front and back
  logic     q_valid;
  logic     q_take;
  in_item_t q_item;

  // front: takes items, drops idle ones, buffers the rest
  sha_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take)
  );

  // back: packs bytes, pads, compresses and reads out the digest words
  sha_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
